@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/lfbp_pkg.sv @@
// shared types and constants for the lsb first field bit packer
// no dependencies
`default_nettype none

package lfbp_pkg;

  localparam int MAX_FIELD_BITS = 64;
  localparam int VAL_W          = 64;
  localparam int WIDTH_W        = 7;
  localparam int BYTE_W         = 8;
  localparam int HOLD_W         = BYTE_W - 1;
  localparam int SH_W           = $clog2(BYTE_W);
  localparam int ACC_W          = VAL_W + HOLD_W;
  localparam int CNT_W          = $clog2(ACC_W + 1);
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

endpackage

`default_nettype wire

@@ rtl/lfbp_front.sv @@
// front part: accepts a field word, saturates its width and masks its value
// depends on lfbp_pkg
`default_nettype none

module lfbp_front
  import lfbp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VAL_W-1:0]   in_field_value,
  input  wire logic        [WIDTH_W-1:0] in_field_width,
  input  wire logic                      in_last_field,
  input  wire q_stat_t                   q_stat,
  output logic                           push,
  output item_t                          push_item
);

  logic               f_vld_r, f_vld_nxt;
  item_t              f_item_r, f_item_nxt;
  logic [WIDTH_W-1:0] wsat;
  logic [VAL_W-1:0]   vmask;
  logic               in_acc;

  assign in_stall  = f_vld_r && q_stat.full;
  assign in_acc    = in_valid && !in_stall;
  assign push      = f_vld_r && !q_stat.full;
  assign push_item = f_item_r;

  always_comb begin
    wsat = (in_field_width > WIDTH_W'(MAX_FIELD_BITS)) ? WIDTH_W'(MAX_FIELD_BITS)
                                                       : in_field_width;
    if (wsat >= WIDTH_W'(VAL_W)) begin
      vmask = '1;
    end else begin
      vmask = (VAL_W'(1) << wsat) - VAL_W'(1);
    end
    f_item_nxt = f_item_r;
    f_vld_nxt  = f_vld_r;
    if (push) begin
      f_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      f_vld_nxt        = 1'b1;
      f_item_nxt.value = VAL_W'(in_field_value) & vmask;
      f_item_nxt.width = wsat;
      f_item_nxt.last  = in_last_field;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
    f_item_r <= f_item_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/lfbp_queue.sv @@
// short queue of masked field words between front and back
// depends on lfbp_pkg
`default_nettype none

module lfbp_queue
  import lfbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output q_stat_t    q_stat
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + Q_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - Q_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lfbp_back.sv @@
// back part: merges held bits with a field and emits bytes through an output register
// depends on lfbp_pkg
`default_nettype none

module lfbp_back
  import lfbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_stat_t     q_stat,
  input  wire item_t       pop_item,
  output bk_stat_t         bk_stat,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic             out_last_byte
);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic              busy_r, busy_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              pop;
  logic              out_ok;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  rem;

  assign pop           = !busy_r && !q_stat.empty;
  assign out_ok        = !ov_r || !out_stall;
  assign bk_stat.busy  = busy_r;
  assign bk_stat.pop   = pop;
  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_last_byte = ol_r;

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    total    = cnt_r + CNT_W'(pop_item.width);
    rem      = cnt_r - CNT_W'(BYTE_W);
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      acc_nxt  = ACC_W'(acc_r[HOLD_W-1:0]) | (ACC_W'(pop_item.value) << cnt_r[SH_W-1:0]);
      cnt_nxt  = total;
      last_nxt = pop_item.last;
      busy_nxt = (total >= CNT_W'(BYTE_W)) || (pop_item.last && (total != '0));
    end else if (busy_r && out_ok) begin
      ov_nxt = 1'b1;
      ob_nxt = acc_r[BYTE_W-1:0];
      if (last_r && (cnt_r <= CNT_W'(BYTE_W))) begin
        // final word of the message, held state clears
        ol_nxt   = 1'b1;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b0;
      end else begin
        ol_nxt   = 1'b0;
        acc_nxt  = acc_r >> BYTE_W;
        cnt_nxt  = rem;
        busy_nxt = (rem >= CNT_W'(BYTE_W)) || (last_r && (rem != '0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      last_r <= 1'b0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/lsb_first_field_bit_packer.sv @@
// path: an accepted field word passes the front register, the queue and the back accumulator
//   before its first byte is loaded into the byte-wide output register
// throughput: one field word per cycle into the queue while it is not full; one byte per cycle
//   out while busy and out_stall is low; the back part pops a new word only once all bytes are out
// reset: rst_n synchronous, active low; clears valid flags, queue pointers and held bits
// top level: front, queue and back; depends on lfbp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lsb_first_field_bit_packer
  import lfbp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VAL_W-1:0]   in_field_value,
  input  wire logic        [WIDTH_W-1:0] in_field_width,
  input  wire logic                      in_last_field,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic             [BYTE_W-1:0]  out_byte,
  output logic                           out_last_byte
);

  q_stat_t  q_stat;
  bk_stat_t bk_stat;
  logic     push;
  item_t    push_item;
  item_t    pop_item;

  lfbp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_field_value (in_field_value),
    .in_field_width (in_field_width),
    .in_last_field  (in_last_field),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  lfbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (bk_stat.pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  lfbp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_item      (pop_item),
    .bk_stat       (bk_stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  `ASSERT_NEVER(a_q_full_and_empty, q_stat.full && q_stat.empty, "queue full and empty")
  `ASSERT_NEVER(a_push_when_full, push && q_stat.full, "push into full queue")
  `ASSERT_CLK(a_out_from_busy, $rose(out_valid) |-> $past(bk_stat.busy), "word without work")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for lsb_first_field_bit_packer: directed fields, then random messages
// expected bytes: in-bench packer or typed table row; depends on lfbp_pkg and the rtl only

module testbench;
  import lfbp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_WORDS = 82;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } byte_word_t;

  typedef struct {
    logic [VAL_W-1:0]   value;
    logic [WIDTH_W-1:0] width;
    logic               last;
    bit                 typed;
    int unsigned        n;
    logic [71:0]        bytes;
  } field_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic        [VAL_W-1:0]   in_field_value;
  logic        [WIDTH_W-1:0] in_field_width;
  logic                      in_last_field;
  logic                      out_valid;
  logic                      out_stall;
  logic        [BYTE_W-1:0]  out_byte;
  logic                      out_last_byte;

  // typed expectation travels alongside the field word
  bit                        row_typed;
  int unsigned               row_n;
  logic [71:0]               row_bytes;

  int unsigned               send_idle_pct;
  int unsigned               recv_stall_pct;

  byte_word_t                expected_bytes[$];
  field_row_t                field_table[$];
  logic [HOLD_W-1:0]         carry_bits;
  int unsigned               carry_cnt;
  int unsigned               mismatches;
  int unsigned               fields_seen;
  int unsigned               messages_seen;
  int unsigned               bytes_checked;

  wire in_fire  = rst_n && in_valid && !in_stall;
  wire out_fire = rst_n && out_valid && !out_stall;

  lsb_first_field_bit_packer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_field_value (in_field_value),
    .in_field_width (in_field_width),
    .in_last_field  (in_last_field),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // appends one field to the bit stream, returns the bytes it completes
  function automatic int unsigned pack_field(input logic [VAL_W-1:0] v,
                                             input logic [WIDTH_W-1:0] w, input logic l,
                                             output logic [71:0] bytes);
    logic [71:0] stream;
    logic [VAL_W-1:0] masked;
    int unsigned nbits, total, k, n;
    nbits = (w > MAX_FIELD_BITS) ? MAX_FIELD_BITS : w;
    masked = (nbits < 64) ? (v & ((64'd1 << nbits) - 64'd1)) : v;
    stream = (72'(masked) << carry_cnt) | 72'(carry_bits);
    total = carry_cnt + nbits;
    bytes = '0;
    n = 0;
    for (k = 0; k + 8 <= total; k += 8) begin
      bytes[8*n +: 8] = stream[k +: 8];
      n++;
    end
    if (l) begin
      if (total > k) begin
        bytes[8*n +: 8] = stream[k +: 8];
        n++;
      end
      carry_bits = '0;
      carry_cnt = 0;
    end else begin
      carry_bits = stream[k +: 7];
      carry_cnt = total - k;
    end
    return n;
  endfunction

  always @(posedge clk) begin : scoreboard
    int unsigned n, k;
    logic [71:0] bytes;
    byte_word_t want;
    if (!rst_n) begin
      carry_bits = '0;
      carry_cnt = 0;
    end else begin
      if (out_fire) begin
        if (expected_bytes.size() == 0) begin
          $error("out word 0x%02h (last %0b) with no byte expected", out_byte, out_last_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.b) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.b, out_byte);
            mismatches++;
          end
          if (out_last_byte !== want.last) begin
            $error("out_last_byte: expected %0b, got %0b", want.last, out_last_byte);
            mismatches++;
          end
          bytes_checked++;
        end
      end
      if (in_fire) begin
        n = pack_field(in_field_value, in_field_width, in_last_field, bytes);
        if (row_typed) begin
          n = row_n;
          bytes = row_bytes;
        end
        for (k = 0; k < n; k++)
          expected_bytes.push_back({bytes[8*k +: 8], in_last_field && (k == n - 1)});
        fields_seen++;
        if (in_last_field)
          messages_seen++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire)
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: %0d cycles without a word moving", QUIET_LIMIT);
    $display("** lsb_first_field_bit_packer: FAILED **");
    $finish;
  end

  task automatic table_row(input logic [VAL_W-1:0] v, input logic [WIDTH_W-1:0] w,
                           input logic l, input bit typed, input int unsigned n,
                           input logic [71:0] bytes);
    field_row_t r;
    r.value = v;
    r.width = w;
    r.last = l;
    r.typed = typed;
    r.n = n;
    r.bytes = bytes;
    field_table.push_back(r);
  endtask

  task automatic put_field(input logic [VAL_W-1:0] v, input logic [WIDTH_W-1:0] w,
                           input logic l, input bit typed, input int unsigned n,
                           input logic [71:0] bytes);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_field_value <= v;
    in_field_width <= w;
    in_last_field  <= l;
    row_typed      <= typed;
    row_n          <= n;
    row_bytes      <= bytes;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] rand_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return '0;
    if (r < 9)
      return 7'($urandom_range(65, 127));
    if (r < 20)
      return 7'(MAX_FIELD_BITS);
    if (r < 45)
      return 7'($urandom_range(1, 8));
    return 7'($urandom_range(1, 63));
  endfunction

  initial begin : stimulus
    int unsigned sent, nf, i;
    logic lst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_field_value = '0;
    in_field_width = '0;
    in_last_field = 1'b0;
    out_stall = 1'b0;
    row_typed = 1'b0;
    row_n = 0;
    row_bytes = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    fields_seen = 0;
    messages_seen = 0;
    bytes_checked = 0;
    sent = 0;

    table_row(64'hA5, 7'd8, 1'b1, 1, 1, 72'hA5);
    table_row('1, 7'd64, 1'b1, 1, 8, 72'hFFFF_FFFF_FFFF_FFFF);
    table_row(64'h8000_0000_0000_0000, 7'd64, 1'b1, 1, 8, 72'h8000_0000_0000_0000);
    table_row(64'h7FFF_FFFF_FFFF_FFFF, 7'd64, 1'b1, 1, 8, 72'h7FFF_FFFF_FFFF_FFFF);
    table_row(64'h1, 7'd1, 1'b1, 1, 1, 72'h01);
    // zero width, nothing held: no bytes at all
    table_row(64'h0, 7'd0, 1'b1, 1, 0, '0);
    table_row('1, 7'd0, 1'b0, 1, 0, '0);
    // widths above the maximum saturate
    table_row('1, 7'd127, 1'b1, 1, 8, 72'hFFFF_FFFF_FFFF_FFFF);
    table_row(64'h0123_4567_89AB_CDEF, 7'd65, 1'b1, 1, 8, 72'h0123_4567_89AB_CDEF);
    // partial then exact byte boundary on the last field
    table_row(64'h5, 7'd3, 1'b0, 1, 0, '0);
    table_row('1, 7'd5, 1'b1, 1, 1, 72'hFD);
    // seven held bits plus 64 new bits on a last field
    table_row(64'h55, 7'd7, 1'b0, 1, 0, '0);
    table_row('1, 7'd64, 1'b1, 0, 0, '0);
    // zero width last field flushes what is held
    table_row(64'hA, 7'd4, 1'b0, 1, 0, '0);
    table_row(64'h0, 7'd0, 1'b1, 1, 1, 72'h0A);
    table_row(64'hFFFF_FFFF_FFFF_FFFE, 7'd2, 1'b1, 1, 1, 72'h02);
    table_row(64'h3, 7'd4, 1'b0, 0, 0, '0);
    table_row(64'hABC, 7'd12, 1'b1, 0, 0, '0);
    table_row(64'h3F, 7'd6, 1'b0, 0, 0, '0);
    table_row(64'h8000_0000_0000_0000, 7'd64, 1'b1, 0, 0, '0);
    table_row(64'h1, 7'd1, 1'b0, 0, 0, '0);
    table_row(64'h0, 7'd0, 1'b0, 0, 0, '0);
    table_row(64'h7F, 7'd8, 1'b0, 0, 0, '0);
    table_row(64'h1, 7'd1, 1'b1, 0, 0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (field_table[r])
      put_field(field_table[r].value, field_table[r].width, field_table[r].last,
                field_table[r].typed, field_table[r].n, field_table[r].bytes);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      while (sent < (p + 1) * PHASE_WORDS) begin
        nf = $urandom_range(1, 6);
        for (i = 0; i < nf; i++) begin
          lst = (i == nf - 1);
          // some broken messages: last mark early or missing
          if ($urandom_range(0, 99) < 10)
            lst = 1'($urandom_range(0, 1));
          put_field(rand_value(), rand_width(), lst, 0, 0, '0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d field words in %0d messages, %0d bytes checked",
             fields_seen, messages_seen, bytes_checked);
    $display("widths 0 to 127, idle and stall phases on both channels");
    if (mismatches == 0) begin
      $display("** lsb_first_field_bit_packer: PASSED **");
    end else begin
      $display("** lsb_first_field_bit_packer: FAILED **");
    end
    $finish;
  end

endmodule
